// ===== design/sim_pkg.sv =====
package sim_pkg;

	localparam int LIST_BITS = 8;
	localparam int Q_DEPTH   = 4;

	// write request from the merge front into the result queue;
	// second is only ever set together with first
	typedef struct packed {
		logic first;
		logic second;
	} sim_push_t;

endpackage

// ===== design/sim_front.sv =====
module sim_front #(
	parameter int POS_BITS   = 20,
	parameter int OWNER_BITS = 16,
	parameter int COUNT_BITS = 24,
	parameter int REC_BITS   = sim_pkg::LIST_BITS + OWNER_BITS + 2 * POS_BITS + 1 + 2 * COUNT_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [sim_pkg::LIST_BITS-1:0] list_id,
	input  logic [OWNER_BITS-1:0]         owner_id,
	input  logic [POS_BITS-1:0]           start_pos,
	input  logic [POS_BITS-1:0]           end_pos,
	input  logic                          last_in_list,
	output sim_pkg::sim_push_t            wr,
	output logic [REC_BITS-1:0]           rec0,
	output logic [REC_BITS-1:0]           rec1
);
	import sim_pkg::*;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	logic                  pend_valid_q;
	logic [LIST_BITS-1:0]  pend_list_q;
	logic [OWNER_BITS-1:0] pend_owner_q;
	logic [POS_BITS-1:0]   pend_start_q;
	logic [POS_BITS-1:0]   pend_end_q;
	logic [COUNT_BITS-1:0] fusions_q;
	logic [COUNT_BITS-1:0] coalesc_q;

	logic [POS_BITS:0]     end_plus1;
	logic                  merge;
	logic                  abut;
	logic                  emit_old;
	logic [LIST_BITS-1:0]  nxt_list;
	logic [OWNER_BITS-1:0] nxt_owner;
	logic [POS_BITS-1:0]   nxt_start;
	logic [POS_BITS-1:0]   nxt_end;
	logic [COUNT_BITS-1:0] nxt_fusions;
	logic [COUNT_BITS-1:0] nxt_coalesc;
	logic [REC_BITS-1:0]   old_rec;
	logic [REC_BITS-1:0]   flush_rec;

	assign end_plus1 = {1'b0, pend_end_q} + {{POS_BITS{1'b0}}, 1'b1};
	assign merge     = pend_valid_q && (list_id == pend_list_q) && (owner_id == pend_owner_q)
		&& ({1'b0, start_pos} <= end_plus1);
	assign abut      = (end_plus1 == {1'b0, start_pos});
	assign emit_old  = accept && pend_valid_q && !merge;

	always_comb begin
		nxt_list    = pend_list_q;
		nxt_owner   = pend_owner_q;
		nxt_start   = pend_start_q;
		nxt_end     = pend_end_q;
		nxt_fusions = fusions_q;
		nxt_coalesc = coalesc_q;
		if (merge) begin
			if (end_pos > pend_end_q) begin
				nxt_end = end_pos;
			end
			if (abut) begin
				nxt_coalesc = (coalesc_q == COUNT_MAX) ? coalesc_q
					: coalesc_q + COUNT_BITS'(1);
			end else begin
				nxt_fusions = (fusions_q == COUNT_MAX) ? fusions_q
					: fusions_q + COUNT_BITS'(1);
			end
		end else begin
			nxt_list  = list_id;
			nxt_owner = owner_id;
			nxt_start = start_pos;
			nxt_end   = end_pos;
		end
	end

	assign old_rec   = {pend_list_q, pend_owner_q, pend_start_q, pend_end_q, 1'b0,
		{COUNT_BITS{1'b0}}, {COUNT_BITS{1'b0}}};
	assign flush_rec = {nxt_list, nxt_owner, nxt_start, nxt_end, 1'b1, nxt_fusions, nxt_coalesc};

	// the emitted old interval always goes ahead of the flush
	always_comb begin
		wr.first  = emit_old || (accept && last_in_list);
		wr.second = emit_old && last_in_list;
		rec0      = emit_old ? old_rec : flush_rec;
		rec1      = flush_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			fusions_q    <= '0;
			coalesc_q    <= '0;
		end else if (accept) begin
			pend_valid_q <= !last_in_list;
			fusions_q    <= last_in_list ? '0 : nxt_fusions;
			coalesc_q    <= last_in_list ? '0 : nxt_coalesc;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_list_q  <= nxt_list;
			pend_owner_q <= nxt_owner;
			pend_start_q <= nxt_start;
			pend_end_q   <= nxt_end;
		end
	end

endmodule

// ===== design/sim_queue.sv =====
module sim_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sim_pkg::sim_push_t wr,
	input  logic [WIDTH-1:0]   wdata0,
	input  logic [WIDTH-1:0]   wdata1,
	input  logic               pop,
	output logic [WIDTH-1:0]   rdata,
	output logic               empty,
	output logic               full
);
	import sim_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wp_q;
	logic [PW-1:0]    rp_q;
	logic [CW-1:0]    cnt_q;

	logic [PW-1:0]    wp1;
	logic [PW-1:0]    wp2;
	logic             do_pop;
	logic [CW-1:0]    n_wr;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign wp1    = next_ptr(wp_q);
	assign wp2    = next_ptr(wp1);
	assign do_pop = pop && !empty;
	assign n_wr   = CW'(wr.first) + CW'(wr.second);

	assign empty = (cnt_q == '0);
	// leave room for a double write
	assign full  = (cnt_q > CW'(DEPTH - 2));
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr.first) begin
			mem_q[wp_q] <= wdata0;
		end
		if (wr.second) begin
			mem_q[wp1] <= wdata1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + n_wr - CW'(do_pop);
			if (wr.second) begin
				wp_q <= wp2;
			end else if (wr.first) begin
				wp_q <= wp1;
			end
			if (do_pop) begin
				rp_q <= next_ptr(rp_q);
			end
		end
	end

endmodule

// ===== design/sorted_interval_merger.sv =====
// Timing: a result is written into the result queue on the edge that transfers
// the input item that causes it; the queue head is read out combinationally.
// Throughput: one item per cycle while full is low; the 4-entry result queue
// raises full at three or more entries, so a list end that emits two results is absorbed.
// Reset: arst_n clears the pending interval, both counts and the queue.
module sorted_interval_merger #(
	parameter int POS_BITS   = 20,
	parameter int OWNER_BITS = 16,
	parameter int COUNT_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [sim_pkg::LIST_BITS-1:0] list_id,
	input  logic [OWNER_BITS-1:0]         owner_id,
	input  logic [POS_BITS-1:0]           start_pos,
	input  logic [POS_BITS-1:0]           end_pos,
	input  logic                          last_in_list,
	output logic                          empty,
	input  logic                          pop,
	output logic [sim_pkg::LIST_BITS-1:0] out_list_id,
	output logic [OWNER_BITS-1:0]         out_owner_id,
	output logic [POS_BITS-1:0]           out_start,
	output logic [POS_BITS-1:0]           out_end,
	output logic                          list_done,
	output logic [COUNT_BITS-1:0]         fusion_count,
	output logic [COUNT_BITS-1:0]         coalescence_count
);
	import sim_pkg::*;

	localparam int REC_BITS = LIST_BITS + OWNER_BITS + 2 * POS_BITS + 1 + 2 * COUNT_BITS;

	logic                accept;
	sim_push_t           wr;
	logic [REC_BITS-1:0] rec0;
	logic [REC_BITS-1:0] rec1;
	logic [REC_BITS-1:0] rdata;

	assign accept = push && !full;

	sim_front #(
		.POS_BITS   (POS_BITS),
		.OWNER_BITS (OWNER_BITS),
		.COUNT_BITS (COUNT_BITS),
		.REC_BITS   (REC_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.list_id      (list_id),
		.owner_id     (owner_id),
		.start_pos    (start_pos),
		.end_pos      (end_pos),
		.last_in_list (last_in_list),
		.wr           (wr),
		.rec0         (rec0),
		.rec1         (rec1)
	);

	sim_queue #(
		.WIDTH (REC_BITS),
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.wdata0 (rec0),
		.wdata1 (rec1),
		.pop    (pop),
		.rdata  (rdata),
		.empty  (empty),
		.full   (full)
	);

	assign {out_list_id, out_owner_id, out_start, out_end, list_done,
		fusion_count, coalescence_count} = rdata;

	a_last_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_in_list) |-> wr.first)
		else $error("list end transferred without a flush write");

	a_second_needs_first: assert property (@(posedge clk) disable iff (!arst_n)
		wr.second |-> wr.first)
		else $error("second queue write without first");

	a_write_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		wr.first |=> !empty)
		else $error("queue empty after a write");

	a_counts_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !list_done) |-> (fusion_count == '0 && coalescence_count == '0))
		else $error("counts nonzero on an ordinary emit");

endmodule
